// ===== design/mgso_pkg.sv =====
// ---------------------------------------------------------------------------
// mgso_pkg: shared types and constants of the gated sine oscillator
// Note frequency table, sine series coefficients, message codes and the
// pipeline control bundle.
// ---------------------------------------------------------------------------
package mgso_pkg;

	// pipeline depth: stage 1 note/gate, 2 phase, 3 fold and square,
	// 4..9 series steps, 10 final multiply, 11 output register
	localparam int PIPE_DEPTH = 11;

	// high nibble of the status byte
	localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
	localparam logic [3:0] MSG_NOTE_OFF = 4'h8;

	localparam int NOTES_PER_OCTAVE = 12;
	localparam int NOTE_COUNT       = 128;

	// a440 equal temperament frequencies of notes 0..11 in Hz, Q32
	localparam logic [63:0] OCT0_FREQ_Q32 [NOTES_PER_OCTAVE] = '{
		64'd35114788961, 64'd37202822971, 64'd39415017943, 64'd41758756875,
		64'd44241861775, 64'd46872619776, 64'd49659810789, 64'd52612736804,
		64'd55741252937, 64'd59055800320, 64'd62567440947, 64'd66287894592
	};

	// fixed point of the sine evaluation
	localparam int Q_FRAC       = 30;
	localparam int X_W          = 31;
	localparam int ACC_W        = 32;
	localparam int HORNER_STEPS = 6;

	// taylor coefficients of sin(pi/2 x) in Q30: x, x^3, ..., x^13
	localparam logic [X_W-1:0] SINE_COEF [HORNER_STEPS+1] = '{
		31'd1686629713, 31'd693598668, 31'd85569306, 31'd5026995,
		31'd172272, 31'd3864, 31'd61
	};

	typedef logic [X_W-1:0]   q30_t;
	typedef logic [ACC_W-1:0] acc_t;

	// per stage load enables and valid flags
	typedef struct packed {
		logic [PIPE_DEPTH:1] load;
		logic [PIPE_DEPTH:1] valid;
	} pipe_ctrl_t;

endpackage

// ===== design/mgso_flow.sv =====
// ---------------------------------------------------------------------------
// mgso_flow: pipeline flow control
// Valid flags per stage and a ready chain that lets bubbles close up while
// the output register waits.
// ---------------------------------------------------------------------------
module mgso_flow import mgso_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output pipe_ctrl_t ctrl
);

	logic [PIPE_DEPTH:1]   valid_q;
	logic [PIPE_DEPTH+1:1] free;
	logic [PIPE_DEPTH:1]   prev_valid;

	// a stage may load when it is empty or its content moves on
	assign free[PIPE_DEPTH+1] = out_ready;
	for (genvar k = 1; k <= PIPE_DEPTH; k++) begin : g_free
		assign free[k] = !valid_q[k] || free[k+1];
	end

	assign prev_valid = {valid_q[PIPE_DEPTH-1:1], in_valid};

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= (free[PIPE_DEPTH:1] & prev_valid) | (~free[PIPE_DEPTH:1] & valid_q);
		end
	end

	assign ctrl.load  = free[PIPE_DEPTH:1];
	assign ctrl.valid = valid_q;
	assign in_ready   = free[1];
	assign out_valid  = valid_q[PIPE_DEPTH];

	// input stalls only when every stage holds a transaction
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (&valid_q))
		else $error("input stalled with a bubble in the pipeline");

endmodule

// ===== design/mgso_phase.sv =====
// ---------------------------------------------------------------------------
// mgso_phase: note event decode and phase accumulator
// Holds note and gate, looks up the phase increment of the note and
// advances the phase once per transaction.
// ---------------------------------------------------------------------------
module mgso_phase import mgso_pkg::*; #(
	parameter int SAMPLE_RATE = 48000,
	parameter int PHASE_BITS  = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic                  has_event,
	input  logic [7:0]            status_byte,
	input  logic [6:0]            note_number,
	input  pipe_ctrl_t            ctrl,
	output logic [PHASE_BITS-1:0] phase,
	output logic                  gate
);

	localparam logic [63:0] DEN = 64'(SAMPLE_RATE) << (32 - PHASE_BITS);

	logic [6:0]            note_q;
	logic                  gate_q;
	logic [6:0]            note_d;
	logic                  gate_d;
	logic [PHASE_BITS-1:0] phase_q;
	logic                  gate_s2;
	logic [PHASE_BITS-1:0] inc_tab [NOTE_COUNT];

	// increment per note, rounded half up, worked out at elaboration
	for (genvar n = 0; n < NOTE_COUNT; n++) begin : g_inc
		localparam logic [63:0] NUM =
			OCT0_FREQ_Q32[n % NOTES_PER_OCTAVE] << (n / NOTES_PER_OCTAVE);
		localparam logic [63:0] INC = (NUM + DEN / 2) / DEN;
		assign inc_tab[n] = INC[PHASE_BITS-1:0];
	end

	// note on / note off decode, other messages leave the state alone
	always_comb begin
		note_d = note_q;
		gate_d = gate_q;
		if (has_event) begin
			unique case (status_byte[7:4])
				MSG_NOTE_ON: begin
					note_d = note_number;
					gate_d = 1'b1;
				end
				MSG_NOTE_OFF: begin
					note_d = note_number;
					gate_d = 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// note, gate and phase state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_q  <= '0;
			gate_q  <= 1'b0;
			phase_q <= '0;
		end else begin
			if (accept) begin
				note_q <= note_d;
				gate_q <= gate_d;
			end
			if (ctrl.load[2] && ctrl.valid[1]) begin
				phase_q <= phase_q + inc_tab[note_q];
			end
		end
	end

	// gate travels with its transaction
	always_ff @(posedge clk) begin
		if (ctrl.load[2]) begin
			gate_s2 <= gate_q;
		end
	end

	assign phase = phase_q;
	assign gate  = gate_s2;

	// phase only moves when a transaction enters stage 2
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.load[2] && ctrl.valid[1]) |=> $stable(phase_q))
		else $error("phase moved without a transaction");

	// a note on event leaves the gate open
	a_note_on: assert property (@(posedge clk) disable iff (!arst_n)
		accept && has_event && (status_byte[7:4] == MSG_NOTE_ON) |=> gate_q)
		else $error("gate closed after note on");

endmodule

// ===== design/mgso_sine.sv =====
// ---------------------------------------------------------------------------
// mgso_sine: pipelined sine of the phase
// Quadrant fold, odd taylor series by Horner's rule one multiply per stage,
// rounding, saturation, sign and gating into the output register.
// ---------------------------------------------------------------------------
module mgso_sine import mgso_pkg::*; #(
	parameter int PHASE_BITS  = 24,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pipe_ctrl_t                    ctrl,
	input  logic [PHASE_BITS-1:0]         phase,
	input  logic                          gate,
	output logic signed [SAMPLE_BITS-1:0] sample
);

	localparam q30_t       Q30_ONE = X_W'(1) << Q_FRAC;
	localparam logic [32:0] RND    = 33'(1) << (30 - SAMPLE_BITS);
	localparam logic [32:0] MAXV   = (33'(1) << (SAMPLE_BITS - 1)) - 33'(1);

	// stage 3 fold and square
	logic [31:0]      p32;
	logic [1:0]       quad;
	q30_t             frac;
	q30_t             x;
	logic [2*X_W-1:0] sq;

	// horner stages: index 0 is stage 3, index j+1 is stage 4+j
	acc_t       acc_sh  [HORNER_STEPS+1];
	q30_t       x_sh    [HORNER_STEPS+1];
	q30_t       x2_sh   [HORNER_STEPS+1];
	logic [1:0] quad_sh [HORNER_STEPS+1];
	logic       gate_sh [HORNER_STEPS+1];

	// stages 10 and 11
	logic [63:0]                  yprod;
	acc_t                         y_s10;
	logic [1:0]                   quad_s10;
	logic                         gate_s10;
	logic [32:0]                  rnd;
	logic [32:0]                  mag_full;
	logic [SAMPLE_BITS-1:0]       mag;
	logic [SAMPLE_BITS-1:0]       signed_mag;
	logic signed [SAMPLE_BITS-1:0] sample_s11;

	// fold the phase into one quadrant, x in Q30 over [0,1]
	assign p32  = 32'(phase) << (32 - PHASE_BITS);
	assign quad = p32[31:30];
	assign frac = {1'b0, p32[29:0]};
	assign x    = quad[0] ? (Q30_ONE - frac) : frac;
	assign sq   = {{X_W{1'b0}}, x} * {{X_W{1'b0}}, x};

	always_ff @(posedge clk) begin
		if (ctrl.load[3]) begin
			x_sh[0]    <= x;
			x2_sh[0]   <= sq[2*Q_FRAC:Q_FRAC];
			quad_sh[0] <= quad;
			gate_sh[0] <= gate;
		end
	end

	assign acc_sh[0] = ACC_W'(SINE_COEF[HORNER_STEPS]);

	// one horner step per stage: acc = c[k] - acc * x^2
	for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_horner
		logic [ACC_W+X_W-1:0] prod;
		acc_t                 acc_next;

		assign prod     = {{X_W{1'b0}}, acc_sh[j]} * {{ACC_W{1'b0}}, x2_sh[j]};
		assign acc_next = ACC_W'(SINE_COEF[HORNER_STEPS-1-j]) - prod[Q_FRAC+ACC_W-1:Q_FRAC];

		always_ff @(posedge clk) begin
			if (ctrl.load[4+j]) begin
				acc_sh[j+1]  <= acc_next;
				x_sh[j+1]    <= x_sh[j];
				x2_sh[j+1]   <= x2_sh[j];
				quad_sh[j+1] <= quad_sh[j];
				gate_sh[j+1] <= gate_sh[j];
			end
		end
	end

	// final multiply by x
	assign yprod = {{(64-ACC_W){1'b0}}, acc_sh[HORNER_STEPS]} *
		{{(64-X_W){1'b0}}, x_sh[HORNER_STEPS]};

	always_ff @(posedge clk) begin
		if (ctrl.load[10]) begin
			y_s10    <= yprod[Q_FRAC+ACC_W-1:Q_FRAC];
			quad_s10 <= quad_sh[HORNER_STEPS];
			gate_s10 <= gate_sh[HORNER_STEPS];
		end
	end

	// round half up, saturate, apply the half period sign and the gate
	assign rnd        = {1'b0, y_s10} + RND;
	assign mag_full   = rnd >> (31 - SAMPLE_BITS);
	assign mag        = (mag_full > MAXV) ? MAXV[SAMPLE_BITS-1:0]
		: mag_full[SAMPLE_BITS-1:0];
	assign signed_mag = quad_s10[1] ? (~mag + SAMPLE_BITS'(1)) : mag;

	always_ff @(posedge clk) begin
		if (ctrl.load[11]) begin
			sample_s11 <= gate_s10 ? signed'(signed_mag) : '0;
		end
	end

	assign sample = sample_s11;

	// a closed gate gives silence
	a_gate_silent: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load[11] && ctrl.valid[10] && !gate_s10 |=> (sample == '0))
		else $error("nonzero sample with gate off");

endmodule

// ===== design/midi_gated_sine_oscillator.sv =====
// ---------------------------------------------------------------------------
// midi_gated_sine_oscillator: note-gated sine oscillator
// Throughput: one transaction per cycle while the output is ready, set by the
// phase add and one registered multiply per series stage.
// Reset: arst_n clears phase, note, gate and all valid flags; the block is
// ready as soon as reset is released.
// ---------------------------------------------------------------------------
module midi_gated_sine_oscillator import mgso_pkg::*; #(
	parameter int SAMPLE_RATE = 48000,
	parameter int PHASE_BITS  = 24,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          has_event,
	input  logic [7:0]                    status_byte,
	input  logic [6:0]                    note_number,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample
);

	pipe_ctrl_t            ctrl;
	logic                  accept;
	logic [PHASE_BITS-1:0] phase;
	logic                  gate;

	assign accept = in_valid && in_ready;

	// stage flow control
	mgso_flow u_flow (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctrl      (ctrl)
	);

	// note state and phase accumulator
	mgso_phase #(
		.SAMPLE_RATE (SAMPLE_RATE),
		.PHASE_BITS  (PHASE_BITS)
	) u_phase (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.has_event   (has_event),
		.status_byte (status_byte),
		.note_number (note_number),
		.ctrl        (ctrl),
		.phase       (phase),
		.gate        (gate)
	);

	// sine pipeline
	mgso_sine #(
		.PHASE_BITS  (PHASE_BITS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_sine (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.phase  (phase),
		.gate   (gate),
		.sample (sample)
	);

endmodule

// ===== dv/tb_midi_gated_sine_oscillator.sv =====
// ---------------------------------------------------------------------------
// tb_midi_gated_sine_oscillator: self-checking bench of the gated sine oscillator
// Sends sample ticks with and without MIDI note messages, predicts the note,
// gate and phase of each tick, and checks every output sample in order.
// Both handshakes idle and stall at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_midi_gated_sine_oscillator;
	import mgso_pkg::*;

	localparam int SAMPLE_RATE = 48000;
	localparam int PHASE_BITS  = 24;
	localparam int SAMPLE_BITS = 16;
	localparam int RANDOM_TICKS = 1800;

	// a440 equal temperament, notes 0..11 in Hz, Q32
	localparam logic [63:0] NOTE_FREQ_Q32 [12] = '{
		64'd35114788961, 64'd37202822971, 64'd39415017943, 64'd41758756875,
		64'd44241861775, 64'd46872619776, 64'd49659810789, 64'd52612736804,
		64'd55741252937, 64'd59055800320, 64'd62567440947, 64'd66287894592
	};

	// sin(pi/2 x) series terms in Q30, x up to x^13
	localparam logic [63:0] SINE_TERMS [7] = '{
		64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995,
		64'd172272, 64'd3864, 64'd61
	};

	typedef struct {
		bit       has_event;
		bit [7:0] status_byte;
		bit [6:0] note_number;
	} tick_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic                          has_event = 1'b0;
	logic [7:0]                    status_byte = 8'h00;
	logic [6:0]                    note_number = 7'h00;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic signed [SAMPLE_BITS-1:0] sample;

	tick_t                   tick_q[$];
	logic [SAMPLE_BITS-1:0]  expected_samples[$];
	tick_t                   cur_tick;
	int                      errors = 0;

	// predicted oscillator state
	logic [PHASE_BITS-1:0]   osc_phase = '0;
	logic                    osc_gate = 1'b0;
	logic [6:0]              osc_note = '0;

	int                      send_wait = 0;
	int                      recv_wait = 0;
	bit                      send_burst = 1'b0;
	bit                      recv_burst = 1'b0;

	midi_gated_sine_oscillator #(
		.SAMPLE_RATE(SAMPLE_RATE),
		.PHASE_BITS(PHASE_BITS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.has_event(has_event),
		.status_byte(status_byte),
		.note_number(note_number),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample(sample)
	);

	always #6 clk = ~clk;

	// phase step per tick for a note, rounded half up
	function automatic logic [PHASE_BITS-1:0] note_step(input logic [6:0] n);
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] q;
		num = NOTE_FREQ_Q32[n % 12] << (n / 12);
		den = 64'(SAMPLE_RATE) << (32 - PHASE_BITS);
		q = (num + den / 2) / den;
		return q[PHASE_BITS-1:0];
	endfunction

	// quadrant-folded series evaluation of the sine at a phase
	function automatic logic [SAMPLE_BITS-1:0] sine_of_phase(input logic [PHASE_BITS-1:0] ph);
		logic [31:0] p32;
		logic [63:0] frac;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] acc;
		logic [63:0] y;
		logic [63:0] mag;
		logic [63:0] maxv;
		p32 = 32'(ph) << (32 - PHASE_BITS);
		frac = 64'(p32[29:0]);
		x = p32[30] ? (64'd1 << 30) - frac : frac;
		x2 = (x * x) >> 30;
		acc = SINE_TERMS[6];
		for (int k = 5; k >= 0; k--) begin
			acc = SINE_TERMS[k] - ((acc * x2) >> 30);
		end
		y = (acc * x) >> 30;
		mag = (y + (64'd1 << (30 - SAMPLE_BITS))) >> (31 - SAMPLE_BITS);
		maxv = (64'd1 << (SAMPLE_BITS - 1)) - 1;
		if (mag > maxv) begin
			mag = maxv;
		end
		return p32[31] ? SAMPLE_BITS'(-mag) : SAMPLE_BITS'(mag);
	endfunction

	// advance the predicted oscillator by one accepted tick
	task automatic predict_sample(input tick_t t);
		if (t.has_event) begin
			if (t.status_byte[7:4] == MSG_NOTE_ON) begin
				osc_note = t.note_number;
				osc_gate = 1'b1;
			end else if (t.status_byte[7:4] == MSG_NOTE_OFF) begin
				osc_note = t.note_number;
				osc_gate = 1'b0;
			end
		end
		osc_phase = osc_phase + note_step(osc_note);
		expected_samples.push_back(osc_gate ? sine_of_phase(osc_phase) : '0);
	endtask

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		errors++;
	endtask

	// idle cycles before the next transaction, with runs of no idling
	function automatic int draw_wait(inout bit burst);
		if ($urandom_range(0, 63) == 0) begin
			burst = !burst;
		end
		return burst ? 0 : $urandom_range(0, 15);
	endfunction

	task automatic push_tick(input bit ev, input bit [7:0] st, input bit [6:0] nt);
		tick_t t;
		t.has_event = ev;
		t.status_byte = st;
		t.note_number = nt;
		tick_q.push_back(t);
	endtask

	// wait until every pending tick is sent and every sample has come back
	task automatic wait_drained();
		while (tick_q.size() != 0 || in_valid || expected_samples.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// random ticks: mostly plain ticks and note messages, some stray status bytes
	task automatic push_random_ticks(input int count);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 68) begin
				push_tick(1'b0, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
			end else if (r < 84) begin
				push_tick(1'b1, {MSG_NOTE_ON, 4'($urandom_range(0, 15))},
					7'($urandom_range(0, 127)));
			end else if (r < 94) begin
				push_tick(1'b1, {MSG_NOTE_OFF, 4'($urandom_range(0, 15))},
					7'($urandom_range(0, 127)));
			end else begin
				push_tick(1'b1, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
			end
		end
	endtask

	// driver: presents queued ticks, predicts each accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			has_event <= 1'b0;
			status_byte <= 8'h00;
			note_number <= 7'h00;
		end else begin
			if (in_valid && in_ready) begin
				predict_sample(cur_tick);
			end
			if (!in_valid || in_ready) begin
				if (send_wait > 0) begin
					send_wait--;
					in_valid <= 1'b0;
				end else if (tick_q.size() != 0) begin
					cur_tick = tick_q.pop_front();
					has_event <= cur_tick.has_event;
					status_byte <= cur_tick.status_byte;
					note_number <= cur_tick.note_number;
					in_valid <= 1'b1;
					send_wait = draw_wait(send_burst);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each accepted sample against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_samples.size() == 0) begin
					report_mismatch($sformatf("unexpected sample %0d", sample));
				end else begin
					logic [SAMPLE_BITS-1:0] exp_sample;
					exp_sample = expected_samples.pop_front();
					if (sample !== exp_sample) begin
						report_mismatch($sformatf("sample %0d, predicted %0d",
							sample, $signed(exp_sample)));
					end
				end
				recv_wait = draw_wait(recv_burst);
			end
			if (recv_wait > 0) begin
				recv_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// stimulus sequence
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: gate off at reset, note on/off on any channel, stray status
		push_tick(1'b0, 8'h00, 7'h00);
		push_tick(1'b0, 8'h90, 7'd69);
		push_tick(1'b1, 8'h90, 7'd69);
		push_tick(1'b0, 8'h00, 7'h00);
		push_tick(1'b0, 8'h80, 7'd5);
		push_tick(1'b1, 8'h9f, 7'd127);
		push_tick(1'b0, 8'hff, 7'h7f);
		push_tick(1'b1, 8'hf0, 7'd0);
		push_tick(1'b1, 8'ha5, 7'd60);
		push_tick(1'b1, 8'h8f, 7'd69);
		push_tick(1'b0, 8'h00, 7'h00);
		push_tick(1'b1, 8'h00, 7'd127);
		push_tick(1'b1, 8'hff, 7'h55);
		push_tick(1'b1, 8'h93, 7'd0);
		push_tick(1'b0, 8'h00, 7'h00);
		push_tick(1'b1, 8'h70, 7'd42);
		push_tick(1'b1, 8'h80, 7'd0);
		push_tick(1'b1, 8'h95, 7'h2a);
		push_tick(1'b1, 8'h9a, 7'h55);
		push_tick(1'b1, 8'h8a, 7'd127);
		push_tick(1'b1, 8'h9c, 7'd127);
		push_tick(1'b0, 8'h55, 7'h2a);
		push_tick(1'b0, 8'haa, 7'h55);
		wait_drained();

		// random ticks, with a full pause halfway through
		push_random_ticks(RANDOM_TICKS / 2);
		wait_drained();
		push_random_ticks(RANDOM_TICKS - RANDOM_TICKS / 2);
		wait_drained();
		repeat (PIPE_DEPTH + 4) @(posedge clk);

		if (errors == 0) begin
			$display("PASS midi_gated_sine_oscillator");
		end else begin
			$display("FAIL midi_gated_sine_oscillator");
		end
		$finish;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("FAIL midi_gated_sine_oscillator");
		$finish;
	end

endmodule
